### rtl/ptz_pkg.sv
// Shared types, constants and rotation microcode for the point transform / depth plot unit.
package ptz_pkg;

  localparam int MAX_PIXELS      = 8192;
  localparam int DEPTH_FRAC_BITS = 24;
  localparam int Z_OFFSET        = 100;

  localparam int COEF_W    = 16;
  localparam int MAT_W     = 32;
  localparam int MAT_N     = 9;
  localparam int ACC_W     = 50;
  localparam int CW        = 49;
  localparam int NUM_W     = 58;
  localparam int DIV_W     = 48;
  localparam int FEED_W    = 32;
  localparam int Q_W       = 32;
  localparam int CNT_W     = 6;
  localparam int IDX_W     = 41;
  localparam int DEPTH_W   = 24;
  localparam int PIX_W     = 13;
  localparam int ZB_ADDR_W = 16;
  localparam int STEP_W    = 5;

  localparam logic [STEP_W-1:0]      UC_LAST    = STEP_W'(21);
  localparam logic [DEPTH_W-1:0]     DEPTH_SAT  = '1;
  // 2^(36+F) / z saturates for z up to 2^(12+F); that is also the first partial remainder
  localparam logic [CW-1:0]          DEP_LIM    = CW'(1) << (12 + DEPTH_FRAC_BITS);
  localparam logic [DIV_W-1:0]       DEP_REM0   = DIV_W'(1) << (12 + DEPTH_FRAC_BITS);
  localparam logic [CNT_W-1:0]       DEP_ITERS  = CNT_W'(DEPTH_W);
  localparam logic [CNT_W-1:0]       PRJ_ITERS  = CNT_W'(Q_W);
  localparam logic signed [COEF_W-1:0] Q14_ONE  = 16'sd16384;
  localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(8192);
  localparam logic signed [ACC_W-1:0]  Z_INIT   = ACC_W'(Z_OFFSET) <<< 36;

  localparam logic ACT_PLOT  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    REG_SIN_A, REG_COS_A, REG_SIN_B, REG_COS_B,
    REG_SIN_C, REG_COS_C, REG_COLS, REG_ROWS
  } cfg_reg_t;

  typedef struct packed {
    logic              action;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [7:0]        texture;
    logic [12:0]       clear_index;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_index;
    logic [7:0]         write_char;
    logic [DEPTH_W-1:0] depth;
    logic               written;
    logic               off_canvas;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] sin_a;
    logic signed [COEF_W-1:0] cos_a;
    logic signed [COEF_W-1:0] sin_b;
    logic signed [COEF_W-1:0] cos_b;
    logic signed [COEF_W-1:0] sin_c;
    logic signed [COEF_W-1:0] cos_c;
  } coef_t;

  typedef enum logic [3:0] {
    OP_SA, OP_CA, OP_SB, OP_CB, OP_SC, OP_CC, OP_ONE, OP_PX, OP_PY, OP_PZ
  } opsel_t;

  typedef enum logic [3:0] {
    D_R00, D_R01, D_R02, D_R10, D_R11, D_R12, D_R20, D_R21, D_R22, D_X, D_Y, D_Z
  } dst_t;

  typedef struct packed {
    logic       use_r;
    logic [3:0] rsel;
    opsel_t     a;
    opsel_t     b;
    opsel_t     c;
    logic       neg;
    logic       first;
    logic       last;
    dst_t       dst;
  } ucode_t;

  typedef enum logic [1:0] {PH_IDLE, PH_M1, PH_M2, PH_AC} rot_phase_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  rem;
    logic [FEED_W-1:0] feed;
    logic [DIV_W-1:0]  divisor;
    logic [CNT_W-1:0]  count;
  } div_req_t;

  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic [ZB_ADDR_W-1:0] addr;
    logic [DEPTH_W-1:0]   data;
  } zb_req_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_ROT, ST_ZCHK, ST_DEP, ST_PRE, ST_SUM, ST_ABS,
    ST_DIV, ST_IDX1, ST_IDX2, ST_IDX3, ST_RD, ST_DONE
  } ptz_state_t;

  function automatic ucode_t mat_op(opsel_t a, opsel_t b, opsel_t c, logic neg,
                                    logic first, logic last, dst_t dst);
    ucode_t u;
    u.use_r = 1'b0;
    u.rsel  = '0;
    u.a     = a;
    u.b     = b;
    u.c     = c;
    u.neg   = neg;
    u.first = first;
    u.last  = last;
    u.dst   = dst;
    return u;
  endfunction

  function automatic ucode_t crd_op(logic [3:0] rsel, opsel_t c, logic first, logic last,
                                    dst_t dst);
    ucode_t u;
    u.use_r = 1'b1;
    u.rsel  = rsel;
    u.a     = OP_ONE;
    u.b     = OP_ONE;
    u.c     = c;
    u.neg   = 1'b0;
    u.first = first;
    u.last  = last;
    u.dst   = dst;
    return u;
  endfunction

  // matrix entries as sums of triple products in Q42, then the nine coordinate products
  function automatic ucode_t ucode(logic [STEP_W-1:0] step);
    ucode_t u;
    unique case (step)
      5'd0:  u = mat_op(OP_CB, OP_CC, OP_ONE, 1'b0, 1'b1, 1'b1, D_R00);
      5'd1:  u = mat_op(OP_SA, OP_SB, OP_CC,  1'b0, 1'b1, 1'b0, D_R01);
      5'd2:  u = mat_op(OP_CA, OP_SC, OP_ONE, 1'b0, 1'b0, 1'b1, D_R01);
      5'd3:  u = mat_op(OP_SA, OP_SC, OP_ONE, 1'b0, 1'b1, 1'b0, D_R02);
      5'd4:  u = mat_op(OP_CA, OP_SB, OP_CC,  1'b1, 1'b0, 1'b1, D_R02);
      5'd5:  u = mat_op(OP_CB, OP_SC, OP_ONE, 1'b1, 1'b1, 1'b1, D_R10);
      5'd6:  u = mat_op(OP_CA, OP_CC, OP_ONE, 1'b0, 1'b1, 1'b0, D_R11);
      5'd7:  u = mat_op(OP_SA, OP_SB, OP_SC,  1'b1, 1'b0, 1'b1, D_R11);
      5'd8:  u = mat_op(OP_SA, OP_CC, OP_ONE, 1'b0, 1'b1, 1'b0, D_R12);
      5'd9:  u = mat_op(OP_CA, OP_SB, OP_SC,  1'b0, 1'b0, 1'b1, D_R12);
      5'd10: u = mat_op(OP_SB, OP_ONE, OP_ONE, 1'b0, 1'b1, 1'b1, D_R20);
      5'd11: u = mat_op(OP_SA, OP_CB, OP_ONE, 1'b1, 1'b1, 1'b1, D_R21);
      5'd12: u = mat_op(OP_CA, OP_CB, OP_ONE, 1'b0, 1'b1, 1'b1, D_R22);
      5'd13: u = crd_op(4'd0, OP_PX, 1'b1, 1'b0, D_X);
      5'd14: u = crd_op(4'd1, OP_PY, 1'b0, 1'b0, D_X);
      5'd15: u = crd_op(4'd2, OP_PZ, 1'b0, 1'b1, D_X);
      5'd16: u = crd_op(4'd3, OP_PX, 1'b1, 1'b0, D_Y);
      5'd17: u = crd_op(4'd4, OP_PY, 1'b0, 1'b0, D_Y);
      5'd18: u = crd_op(4'd5, OP_PZ, 1'b0, 1'b1, D_Y);
      5'd19: u = crd_op(4'd6, OP_PX, 1'b1, 1'b0, D_Z);
      5'd20: u = crd_op(4'd7, OP_PY, 1'b0, 1'b0, D_Z);
      5'd21: u = crd_op(4'd8, OP_PZ, 1'b0, 1'b1, D_Z);
      default: u = crd_op(4'd8, OP_PZ, 1'b0, 1'b1, D_Z);
    endcase
    return u;
  endfunction

endpackage

### rtl/ptz_rotator.sv
// Microcoded multiply-accumulate unit: rotation matrix from the angle terms, then rotated point.
module ptz_rotator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  ptz_pkg::coef_t               coef,
  input  logic signed [15:0]           px,
  input  logic signed [15:0]           py,
  input  logic signed [15:0]           pz,
  output logic                         done,
  output logic signed [ptz_pkg::CW-1:0] x_out,
  output logic signed [ptz_pkg::CW-1:0] y_out,
  output logic signed [ptz_pkg::CW-1:0] z_out
);

  ptz_pkg::rot_phase_t phase_r, phase_nxt;
  logic [ptz_pkg::STEP_W-1:0] step_r, step_nxt;
  logic signed [ptz_pkg::MAT_W-1:0] p_r, p_nxt;
  logic signed [47:0] m_r, m_nxt;
  logic signed [ptz_pkg::ACC_W-1:0] acc_r, acc_nxt, acc_sum, acc_base, m_ext, rnd;
  logic signed [ptz_pkg::MAT_W-1:0] mat_r [0:ptz_pkg::MAT_N-1];
  logic signed [ptz_pkg::CW-1:0] x_r, y_r, z_r;
  logic done_r, done_nxt;
  ptz_pkg::ucode_t uc;
  logic signed [15:0] a_v, b_v, c_v;
  logic signed [ptz_pkg::MAT_W-1:0] prod_ab;

  function automatic logic signed [15:0] opval(ptz_pkg::opsel_t sel, ptz_pkg::coef_t cf,
                                               logic signed [15:0] vx,
                                               logic signed [15:0] vy,
                                               logic signed [15:0] vz);
    logic signed [15:0] v;
    unique case (sel)
      ptz_pkg::OP_SA:  v = cf.sin_a;
      ptz_pkg::OP_CA:  v = cf.cos_a;
      ptz_pkg::OP_SB:  v = cf.sin_b;
      ptz_pkg::OP_CB:  v = cf.cos_b;
      ptz_pkg::OP_SC:  v = cf.sin_c;
      ptz_pkg::OP_CC:  v = cf.cos_c;
      ptz_pkg::OP_PX:  v = vx;
      ptz_pkg::OP_PY:  v = vy;
      ptz_pkg::OP_PZ:  v = vz;
      default:         v = ptz_pkg::Q14_ONE;
    endcase
    return v;
  endfunction

  always_comb begin
    uc      = ptz_pkg::ucode(step_r);
    a_v     = opval(uc.a, coef, px, py, pz);
    b_v     = opval(uc.b, coef, px, py, pz);
    c_v     = opval(uc.c, coef, px, py, pz);
    prod_ab = a_v * b_v;
    m_ext   = ptz_pkg::ACC_W'(m_r);
    if (uc.dst == ptz_pkg::D_Z) begin
      acc_base = ptz_pkg::Z_INIT;
    end else if (uc.dst == ptz_pkg::D_X || uc.dst == ptz_pkg::D_Y) begin
      acc_base = '0;
    end else begin
      acc_base = ptz_pkg::RND_HALF;
    end
    if (!uc.first) begin
      acc_base = acc_r;
    end
    acc_sum = uc.neg ? acc_base - m_ext : acc_base + m_ext;
    rnd     = acc_sum >>> 14;
  end

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    p_nxt     = p_r;
    m_nxt     = m_r;
    acc_nxt   = acc_r;
    done_nxt  = 1'b0;
    unique case (phase_r)
      ptz_pkg::PH_IDLE: begin
        if (start) begin
          phase_nxt = ptz_pkg::PH_M1;
          step_nxt  = '0;
        end
      end
      ptz_pkg::PH_M1: begin
        p_nxt     = uc.use_r ? mat_r[uc.rsel] : prod_ab;
        phase_nxt = ptz_pkg::PH_M2;
      end
      ptz_pkg::PH_M2: begin
        m_nxt     = p_r * c_v;
        phase_nxt = ptz_pkg::PH_AC;
      end
      ptz_pkg::PH_AC: begin
        acc_nxt = acc_sum;
        if (step_r == ptz_pkg::UC_LAST) begin
          phase_nxt = ptz_pkg::PH_IDLE;
          done_nxt  = 1'b1;
        end else begin
          step_nxt  = step_r + 1'b1;
          phase_nxt = ptz_pkg::PH_M1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ptz_pkg::PH_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
    end
    p_r   <= p_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
    if (phase_r == ptz_pkg::PH_AC && uc.last) begin
      unique case (uc.dst)
        ptz_pkg::D_X: x_r <= acc_sum[ptz_pkg::CW-1:0];
        ptz_pkg::D_Y: y_r <= acc_sum[ptz_pkg::CW-1:0];
        ptz_pkg::D_Z: z_r <= acc_sum[ptz_pkg::CW-1:0];
        default:      mat_r[4'(uc.dst)] <= rnd[ptz_pkg::MAT_W-1:0];
      endcase
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

### rtl/ptz_divider.sv
// Restoring divider, one quotient bit per cycle, fed with numerator bits MSB first.
module ptz_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ptz_pkg::div_req_t        req,
  output logic                     done,
  output logic [ptz_pkg::Q_W-1:0]  quo
);

  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [ptz_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ptz_pkg::DIV_W-1:0]  rem_r, rem_nxt, den_r, den_nxt;
  logic [ptz_pkg::FEED_W-1:0] feed_r, feed_nxt;
  logic [ptz_pkg::Q_W-1:0]    quo_r, quo_nxt;
  logic [ptz_pkg::DIV_W:0]    rem2, diff;
  logic                       ge;

  always_comb begin
    rem2     = {rem_r, feed_r[ptz_pkg::FEED_W-1]};
    diff     = rem2 - {1'b0, den_r};
    ge       = rem2 >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    feed_nxt = feed_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.count;
      rem_nxt  = req.rem;
      den_nxt  = req.divisor;
      feed_nxt = req.feed;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[ptz_pkg::DIV_W-1:0] : rem2[ptz_pkg::DIV_W-1:0];
      quo_nxt  = {quo_r[ptz_pkg::Q_W-2:0], ge};
      feed_nxt = {feed_r[ptz_pkg::FEED_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == ptz_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    feed_r <= feed_nxt;
    quo_r  <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/ptz_zbuf.sv
// Depth store: single-port synchronous RAM with a zeroing sweep after reset.
module ptz_zbuf #(
  parameter int MAX_PIXELS = ptz_pkg::MAX_PIXELS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptz_pkg::zb_req_t              req,
  output logic [ptz_pkg::DEPTH_W-1:0]   rd_data,
  output logic                          ready
);

  localparam int AW = $clog2(MAX_PIXELS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);

  logic [ptz_pkg::DEPTH_W-1:0] mem [0:MAX_PIXELS-1];
  logic [ptz_pkg::DEPTH_W-1:0] rd_data_r;
  logic [AW-1:0]               sweep_r, sweep_nxt;
  logic                        ready_r, ready_nxt;
  logic [AW-1:0]               wa;
  logic [ptz_pkg::DEPTH_W-1:0] wd;
  logic                        we;

  always_comb begin
    sweep_nxt = sweep_r;
    ready_nxt = ready_r;
    if (!ready_r) begin
      sweep_nxt = sweep_r + 1'b1;
      if (sweep_r == LAST_ADDR) begin
        ready_nxt = 1'b1;
      end
    end
    we = !ready_r || req.wr;
    wa = ready_r ? req.addr[AW-1:0] : sweep_r;
    wd = ready_r ? req.data : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      ready_r <= 1'b0;
    end else begin
      sweep_r <= sweep_nxt;
      ready_r <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (req.rd) begin
      rd_data_r <= mem[req.addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = ready_r;

endmodule

### rtl/point_transform_zbuffer_plot_unit.sv
// Top level: rotate, project and depth-test one surface point against the depth store, or clear one entry.
//
//  port group  direction  handshake          payload
//  in_*        request in  in_valid/in_stall  ptz_pkg::in_item_t
//  out_*       result out  out_valid/out_stall ptz_pkg::out_item_t
//  cfg_*       write in    cfg_we             cfg_index (3 b), cfg_data (16 b)
//
// A clear request zeroes its entry and goes straight to ST_DONE. A plot request runs the shared
// multiply-accumulate unit (22 microcode steps, each in phases M1, M2 and AC), then the bit-serial
// divider: a 24-bit quotient for 1/z (skipped when it saturates) and 32-bit ones for column and row,
// then the index arithmetic and the depth read-modify-write.
// After reset the depth store is zeroed one entry a cycle, with in_stall high until the sweep ends.
// One request is in flight at a time; a finished result waits in the output register while
// the next request is taken.
module point_transform_zbuffer_plot_unit #(
  parameter int MAX_PIXELS = ptz_pkg::MAX_PIXELS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ptz_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ptz_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam logic [ptz_pkg::IDX_W-1:0] PIX_LIMIT = ptz_pkg::IDX_W'(MAX_PIXELS);

  ptz_pkg::ptz_state_t state_r, state_nxt;
  ptz_pkg::coef_t     coef_r;
  logic [7:0]         cols_r;
  logic [6:0]         rows_r;
  ptz_pkg::in_item_t  item_r, item_nxt;
  ptz_pkg::out_item_t res_r, res_nxt, out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ptz_pkg::DEPTH_W-1:0] dep_r, dep_nxt;
  logic               axis_r, axis_nxt, neg_r, neg_nxt;
  logic signed [ptz_pkg::NUM_W-1:0] cz_r, cz_nxt, sc_r, sc_nxt, num_r, num_nxt;
  logic signed [ptz_pkg::Q_W-1:0]   qx_r, qx_nxt, qy_r, qy_nxt;
  logic signed [ptz_pkg::IDX_W-1:0] qc_r, qc_nxt, idx_r, idx_nxt;

  logic rot_start, rot_done, div_done, zb_ready;
  logic signed [ptz_pkg::CW-1:0] rot_x, rot_y, rot_z;
  logic [ptz_pkg::Q_W-1:0] div_q;
  logic [ptz_pkg::DEPTH_W-1:0] zb_rd;
  ptz_pkg::div_req_t div_req;
  ptz_pkg::zb_req_t  zb_req;

  logic signed [8:0]  dim_s;
  logic signed [ptz_pkg::NUM_W-1:0] xe, ye;
  logic [ptz_pkg::NUM_W-2:0] mag;
  logic [ptz_pkg::DIV_W-1:0] den2;
  logic [ptz_pkg::Q_W-1:0]   qs;
  logic [14:0]               area;
  logic                      q_ok, idx_ok, z_pos;

  ptz_rotator u_rot (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rot_start),
    .coef  (coef_r),
    .px    (item_r.point_x),
    .py    (item_r.point_y),
    .pz    (item_r.point_z),
    .done  (rot_done),
    .x_out (rot_x),
    .y_out (rot_y),
    .z_out (rot_z)
  );

  ptz_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_q)
  );

  ptz_zbuf #(.MAX_PIXELS(MAX_PIXELS)) u_zbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (zb_req),
    .rd_data (zb_rd),
    .ready   (zb_ready)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.sin_a <= '0;
      coef_r.cos_a <= ptz_pkg::Q14_ONE;
      coef_r.sin_b <= '0;
      coef_r.cos_b <= ptz_pkg::Q14_ONE;
      coef_r.sin_c <= '0;
      coef_r.cos_c <= ptz_pkg::Q14_ONE;
      cols_r       <= 8'd128;
      rows_r       <= 7'd64;
    end else if (cfg_we) begin
      unique case (ptz_pkg::cfg_reg_t'(cfg_index))
        ptz_pkg::REG_SIN_A: coef_r.sin_a <= cfg_data;
        ptz_pkg::REG_COS_A: coef_r.cos_a <= cfg_data;
        ptz_pkg::REG_SIN_B: coef_r.sin_b <= cfg_data;
        ptz_pkg::REG_COS_B: coef_r.cos_b <= cfg_data;
        ptz_pkg::REG_SIN_C: coef_r.sin_c <= cfg_data;
        ptz_pkg::REG_COS_C: coef_r.cos_c <= cfg_data;
        ptz_pkg::REG_COLS:  cols_r       <= cfg_data[7:0];
        ptz_pkg::REG_ROWS:  rows_r       <= cfg_data[6:0];
      endcase
    end
  end

  // datapath helpers
  always_comb begin
    dim_s  = axis_r ? $signed({2'b00, rows_r}) : $signed({1'b0, cols_r});
    xe     = ptz_pkg::NUM_W'(rot_x);
    ye     = ptz_pkg::NUM_W'(rot_y);
    mag    = num_r[ptz_pkg::NUM_W-1] ? (ptz_pkg::NUM_W-1)'(-num_r)
                                     : num_r[ptz_pkg::NUM_W-2:0];
    den2   = {rot_z[ptz_pkg::DIV_W-2:0], 1'b0};
    // truncation toward zero: magnitude may reach 2^31 only on the negative side
    q_ok   = !div_q[ptz_pkg::Q_W-1] || (neg_r && div_q[ptz_pkg::Q_W-2:0] == '0);
    qs     = neg_r ? -div_q : div_q;
    area   = cols_r * rows_r;
    z_pos  = !rot_z[ptz_pkg::CW-1] && rot_z != '0;
    idx_ok = !idx_r[ptz_pkg::IDX_W-1] && idx_r < ptz_pkg::IDX_W'(area) && idx_r < PIX_LIMIT;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    dep_nxt       = dep_r;
    axis_nxt      = axis_r;
    neg_nxt       = neg_r;
    cz_nxt        = cz_r;
    sc_nxt        = sc_r;
    num_nxt       = num_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    qc_nxt        = qc_r;
    idx_nxt       = idx_r;
    rot_start     = 1'b0;
    div_req.start   = 1'b0;
    div_req.rem     = ptz_pkg::DIV_W'(mag[ptz_pkg::NUM_W-2:ptz_pkg::Q_W]);
    div_req.feed    = mag[ptz_pkg::Q_W-1:0];
    div_req.divisor = den2;
    div_req.count   = ptz_pkg::PRJ_ITERS;
    zb_req.rd       = 1'b0;
    zb_req.wr       = 1'b0;
    zb_req.addr     = idx_r[ptz_pkg::ZB_ADDR_W-1:0];
    zb_req.data     = dep_r;
    in_stall        = 1'b1;

    unique case (state_r)
      ptz_pkg::ST_INIT: begin
        if (zb_ready) begin
          state_nxt = ptz_pkg::ST_IDLE;
        end
      end
      ptz_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.action == ptz_pkg::ACT_CLEAR) begin
            zb_req.wr   = 32'(in_data.clear_index) < 32'(MAX_PIXELS);
            zb_req.addr = ptz_pkg::ZB_ADDR_W'(in_data.clear_index);
            zb_req.data = '0;
            res_nxt     = '0;
            state_nxt   = ptz_pkg::ST_DONE;
          end else begin
            rot_start = 1'b1;
            state_nxt = ptz_pkg::ST_ROT;
          end
        end
      end
      ptz_pkg::ST_ROT: begin
        if (rot_done) begin
          state_nxt = ptz_pkg::ST_ZCHK;
        end
      end
      ptz_pkg::ST_ZCHK: begin
        axis_nxt = 1'b0;
        if (!z_pos) begin
          res_nxt            = '0;
          res_nxt.off_canvas = 1'b1;
          state_nxt          = ptz_pkg::ST_DONE;
        end else if ($unsigned(rot_z) <= ptz_pkg::DEP_LIM) begin
          dep_nxt   = ptz_pkg::DEPTH_SAT;
          state_nxt = ptz_pkg::ST_PRE;
        end else begin
          div_req.start   = 1'b1;
          div_req.rem     = ptz_pkg::DEP_REM0;
          div_req.feed    = '0;
          div_req.divisor = rot_z[ptz_pkg::DIV_W-1:0];
          div_req.count   = ptz_pkg::DEP_ITERS;
          state_nxt       = ptz_pkg::ST_DEP;
        end
      end
      ptz_pkg::ST_DEP: begin
        if (div_done) begin
          dep_nxt   = div_q[ptz_pkg::DEPTH_W-1:0];
          state_nxt = ptz_pkg::ST_PRE;
        end
      end
      ptz_pkg::ST_PRE: begin
        cz_nxt    = rot_z * dim_s;
        sc_nxt    = axis_r ? (ye <<< 7) - (ye <<< 3) : (xe <<< 8) - (xe <<< 4);
        state_nxt = ptz_pkg::ST_SUM;
      end
      ptz_pkg::ST_SUM: begin
        num_nxt   = cz_r + sc_r;
        state_nxt = ptz_pkg::ST_ABS;
      end
      ptz_pkg::ST_ABS: begin
        neg_nxt = num_r[ptz_pkg::NUM_W-1];
        if (ptz_pkg::DIV_W'(mag[ptz_pkg::NUM_W-2:ptz_pkg::Q_W]) >= den2) begin
          res_nxt            = '0;
          res_nxt.depth      = dep_r;
          res_nxt.off_canvas = 1'b1;
          state_nxt          = ptz_pkg::ST_DONE;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ptz_pkg::ST_DIV;
        end
      end
      ptz_pkg::ST_DIV: begin
        if (div_done) begin
          if (!q_ok) begin
            res_nxt            = '0;
            res_nxt.depth      = dep_r;
            res_nxt.off_canvas = 1'b1;
            state_nxt          = ptz_pkg::ST_DONE;
          end else if (!axis_r) begin
            qx_nxt    = qs;
            axis_nxt  = 1'b1;
            state_nxt = ptz_pkg::ST_PRE;
          end else begin
            qy_nxt    = qs;
            state_nxt = ptz_pkg::ST_IDX1;
          end
        end
      end
      ptz_pkg::ST_IDX1: begin
        qc_nxt    = qy_r * $signed({1'b0, cols_r});
        state_nxt = ptz_pkg::ST_IDX2;
      end
      ptz_pkg::ST_IDX2: begin
        idx_nxt   = ptz_pkg::IDX_W'(qx_r) + qc_r;
        state_nxt = ptz_pkg::ST_IDX3;
      end
      ptz_pkg::ST_IDX3: begin
        if (idx_ok) begin
          zb_req.rd = 1'b1;
          state_nxt = ptz_pkg::ST_RD;
        end else begin
          res_nxt            = '0;
          res_nxt.depth      = dep_r;
          res_nxt.off_canvas = 1'b1;
          state_nxt          = ptz_pkg::ST_DONE;
        end
      end
      ptz_pkg::ST_RD: begin
        res_nxt             = '0;
        res_nxt.pixel_index = idx_r[ptz_pkg::PIX_W-1:0];
        res_nxt.depth       = dep_r;
        if (dep_r > zb_rd) begin
          zb_req.wr          = 1'b1;
          res_nxt.written    = 1'b1;
          res_nxt.write_char = item_r.texture;
        end
        state_nxt = ptz_pkg::ST_DONE;
      end
      ptz_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ptz_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ptz_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptz_pkg::ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    dep_r      <= dep_nxt;
    axis_r     <= axis_nxt;
    neg_r      <= neg_nxt;
    cz_r       <= cz_nxt;
    sc_r       <= sc_nxt;
    num_r      <= num_nxt;
    qx_r       <= qx_nxt;
    qy_r       <= qy_nxt;
    qc_r       <= qc_nxt;
    idx_r      <= idx_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### dv/tb_point_transform_zbuffer_plot_unit.sv
// Testbench for the point transform / depth plot unit: random and directed requests, scoreboarded.
`timescale 1ns / 100ps

module tb_point_transform_zbuffer_plot_unit;

  localparam longint COORD_LIM = 64'sd2147483648;
  localparam longint DEP_NUM   = 64'sd1 <<< (36 + ptz_pkg::DEPTH_FRAC_BITS);

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ptz_pkg::in_item_t   in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ptz_pkg::out_item_t  out_data;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;

  point_transform_zbuffer_plot_unit dut (.*);

  always #10 clk = ~clk;

  ptz_pkg::in_item_t   request_q[$];
  ptz_pkg::out_item_t  expected_pixels[$];
  logic [15:0]     reg_shadow[8];
  logic [23:0]     zbuf[ptz_pkg::MAX_PIXELS];
  int              errors = 0;
  int              n_plot = 0, n_written = 0, n_off = 0, n_clear = 0, n_results = 0;
  int              burst_left = 1, gap_left = 0, stall_mode = 0, stall_cnt = 0;
  logic            took;

  function automatic longint q28_round(longint m);
    return (m + 64'sd8192) >>> 14;
  endfunction

  // rotate, project and depth-test one request against the local depth store
  function automatic ptz_pkg::out_item_t project_point(ptz_pkg::in_item_t it);
    ptz_pkg::out_item_t o;
    longint sa, ca, sb, cb, sc, cc, px, py, pz, cols, rows;
    longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
    longint xr, yr, zr, qx, qy, idx, q;
    logic [23:0] dep;
    o = '0;
    if (it.action == ptz_pkg::ACT_CLEAR) begin
      zbuf[it.clear_index] = '0;
      n_clear++;
      return o;
    end
    n_plot++;
    sa = $signed(reg_shadow[ptz_pkg::REG_SIN_A]); ca = $signed(reg_shadow[ptz_pkg::REG_COS_A]);
    sb = $signed(reg_shadow[ptz_pkg::REG_SIN_B]); cb = $signed(reg_shadow[ptz_pkg::REG_COS_B]);
    sc = $signed(reg_shadow[ptz_pkg::REG_SIN_C]); cc = $signed(reg_shadow[ptz_pkg::REG_COS_C]);
    cols = longint'(reg_shadow[ptz_pkg::REG_COLS][7:0]);
    rows = longint'(reg_shadow[ptz_pkg::REG_ROWS][6:0]);
    px = $signed(it.point_x); py = $signed(it.point_y); pz = $signed(it.point_z);
    r00 = q28_round(cb * cc * 16384);
    r01 = q28_round(sa * sb * cc + ca * sc * 16384);
    r02 = q28_round(sa * sc * 16384 - ca * sb * cc);
    r10 = q28_round(-cb * sc * 16384);
    r11 = q28_round(ca * cc * 16384 - sa * sb * sc);
    r12 = q28_round(sa * cc * 16384 + ca * sb * sc);
    r20 = q28_round(sb * 64'sd268435456);
    r21 = q28_round(-sa * cb * 16384);
    r22 = q28_round(ca * cb * 16384);
    xr = r00 * px + r01 * py + r02 * pz;
    yr = r10 * px + r11 * py + r12 * pz;
    zr = r20 * px + r21 * py + r22 * pz + (longint'(ptz_pkg::Z_OFFSET) <<< 36);
    if (zr <= 0) begin
      o.off_canvas = 1'b1;
      n_off++;
      return o;
    end
    q = DEP_NUM / zr;
    dep = (q > 64'sd16777215) ? 24'hFFFFFF : q[23:0];
    o.depth = dep;
    qx = (cols * zr + 240 * xr) / (2 * zr);
    qy = (rows * zr + 120 * yr) / (2 * zr);
    idx = qx + qy * cols;
    if (qx < -COORD_LIM || qx >= COORD_LIM || qy < -COORD_LIM || qy >= COORD_LIM ||
        idx < 0 || idx >= cols * rows || idx >= ptz_pkg::MAX_PIXELS) begin
      o.off_canvas = 1'b1;
      n_off++;
      return o;
    end
    o.pixel_index = idx[12:0];
    if (dep > zbuf[idx]) begin
      zbuf[idx] = dep;
      o.write_char = it.texture;
      o.written = 1'b1;
      n_written++;
    end
    return o;
  endfunction

  // request driver: bursts and gaps, payload held while stalled
  always @(posedge clk) begin
    took = in_valid && !in_stall;
    if (took) begin
      expected_pixels.push_back(project_point(in_data));
      void'(request_q.pop_front());
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !took) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (request_q.size() > 0) begin
      in_valid <= 1'b1;
      in_data  <= request_q[0];
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      n_results++;
      if (expected_pixels.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data);
        errors++;
      end else begin
        if (out_data !== expected_pixels[0]) begin
          $display("%0t mismatch: exp idx %0d chr %0h dep %0h wr %0b off %0b", $time,
                   expected_pixels[0].pixel_index, expected_pixels[0].write_char,
                   expected_pixels[0].depth, expected_pixels[0].written,
                   expected_pixels[0].off_canvas);
          $display("%0t           got idx %0d chr %0h dep %0h wr %0b off %0b", $time,
                   out_data.pixel_index, out_data.write_char, out_data.depth,
                   out_data.written, out_data.off_canvas);
          errors++;
        end
        void'(expected_pixels.pop_front());
      end
    end
    if (stall_cnt == 0) begin
      stall_cnt  = $urandom_range(50, 400);
      stall_mode = $urandom_range(0, 3);
    end
    stall_cnt--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic write_reg(ptz_pkg::cfg_reg_t r, logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    reg_shadow[r] = v;
  endtask

  task automatic cfg_done();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_angles(real a, real b, real c);
    write_reg(ptz_pkg::REG_SIN_A, 16'($rtoi($sin(a) * 16384.0)));
    write_reg(ptz_pkg::REG_COS_A, 16'($rtoi($cos(a) * 16384.0)));
    write_reg(ptz_pkg::REG_SIN_B, 16'($rtoi($sin(b) * 16384.0)));
    write_reg(ptz_pkg::REG_COS_B, 16'($rtoi($cos(b) * 16384.0)));
    write_reg(ptz_pkg::REG_SIN_C, 16'($rtoi($sin(c) * 16384.0)));
    write_reg(ptz_pkg::REG_COS_C, 16'($rtoi($cos(c) * 16384.0)));
  endtask

  task automatic drain();
    while (request_q.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic ptz_pkg::in_item_t mk_req(logic act, int x, int y, int z, int tex, int ci);
    ptz_pkg::in_item_t it;
    it.action      = act;
    it.point_x     = 16'(x);
    it.point_y     = 16'(y);
    it.point_z     = 16'(z);
    it.texture     = 8'(tex);
    it.clear_index = 13'(ci);
    return it;
  endfunction

  // mostly points near the view axis so they land and collide; some clears and raw noise
  function automatic ptz_pkg::in_item_t rand_req();
    ptz_pkg::in_item_t it;
    int sel, span;
    sel  = $urandom_range(0, 99);
    span = ($urandom_range(0, 1) == 0) ? 2048 : 12800;
    it.point_x     = 16'($urandom);
    it.point_y     = 16'($urandom);
    it.point_z     = 16'($urandom);
    it.texture     = 8'($urandom);
    it.clear_index = 13'($urandom);
    it.action      = ptz_pkg::ACT_PLOT;
    if (sel < 12) begin
      it.action = ptz_pkg::ACT_CLEAR;
      if ($urandom_range(0, 1) == 0) it.clear_index = 13'($urandom_range(0, 255) + 4000);
    end else if (sel < 85) begin
      it.point_x = 16'($urandom_range(0, 2 * span) - span);
      it.point_y = 16'($urandom_range(0, 2 * span) - span);
      it.point_z = 16'($urandom_range(0, 2 * span) - span);
    end
    return it;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) request_q.push_back(rand_req());
    drain();
  endtask

  initial begin
    for (int i = 0; i < ptz_pkg::MAX_PIXELS; i++) zbuf[i] = '0;
    reg_shadow = '{16'd0, 16'd16384, 16'd0, 16'd16384, 16'd0, 16'd16384, 16'd128, 16'd64};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: centre hit, repeat loses depth test, clear, extremes, dropped depth
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, 0, 0, 0, 8'h41, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, 0, 0, 0, 8'h42, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, 0, 0, 256, 8'h43, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_CLEAR, 0, 0, 0, 0, 64 * 128 / 2 + 64));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, 0, 0, 0, 8'hFF, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_CLEAR, 0, 0, 0, 0, 8191));
    request_q.push_back(mk_req(ptz_pkg::ACT_CLEAR, -1, -1, -1, 255, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, 32767, 0, 0, 1, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, -32768, 0, 0, 2, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, 0, 32767, 0, 3, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, 0, -32768, 0, 4, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, 0, 0, 32767, 5, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, 0, 0, -25600, 6, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, 0, 0, -25599, 7, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, 0, 0, -32768, 8, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, -32768, -32768, -25000, 9, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, 32767, 32767, -25500, 10, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, 13000, 6000, 0, 11, 0));
    request_q.push_back(mk_req(ptz_pkg::ACT_PLOT, -13300, -6400, 0, 0, 0));
    drain();

    random_phase(500);

    set_angles(0.7, -1.2, 2.5);
    cfg_done();
    random_phase(400);

    write_reg(ptz_pkg::REG_SIN_A, 16'sd16384);  write_reg(ptz_pkg::REG_COS_A, 16'sd0);
    write_reg(ptz_pkg::REG_SIN_B, -16'sd16384); write_reg(ptz_pkg::REG_COS_B, -16'sd16384);
    write_reg(ptz_pkg::REG_SIN_C, -16'sd16384); write_reg(ptz_pkg::REG_COS_C, 16'sd16384);
    write_reg(ptz_pkg::REG_COLS, 16'd1);        write_reg(ptz_pkg::REG_ROWS, 16'd1);
    cfg_done();
    random_phase(200);

    set_angles(-2.9, 0.3, -0.8);
    write_reg(ptz_pkg::REG_COLS, 16'd128);      write_reg(ptz_pkg::REG_ROWS, 16'd1);
    cfg_done();
    random_phase(300);

    write_reg(ptz_pkg::REG_SIN_A, 16'sd0);      write_reg(ptz_pkg::REG_COS_A, -16'sd16384);
    write_reg(ptz_pkg::REG_SIN_B, 16'sd0);      write_reg(ptz_pkg::REG_COS_B, 16'sd16384);
    write_reg(ptz_pkg::REG_SIN_C, 16'sd0);      write_reg(ptz_pkg::REG_COS_C, 16'sd16384);
    write_reg(ptz_pkg::REG_COLS, 16'd1);        write_reg(ptz_pkg::REG_ROWS, 16'd64);
    cfg_done();
    random_phase(200);

    set_angles(1.9, 2.2, 0.4);
    write_reg(ptz_pkg::REG_COLS, 16'd37);       write_reg(ptz_pkg::REG_ROWS, 16'd23);
    cfg_done();
    random_phase(400);

    $display("Covered %0d plots (%0d written, %0d off canvas or dropped), %0d clears,",
             n_plot, n_written, n_off, n_clear);
    $display("%0d results checked over six register settings.", n_results);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
